>>> sv/cmqe_pkg.sv
// Shared types, constants and identifier helpers for the CAN message queue engine.
// No dependencies; imported by every cmqe module.
`default_nettype none
package cmqe_pkg;

  localparam int TX_DEPTH  = 64;
  localparam int RX_DEPTH  = 64;
  localparam int MAILBOXES = 3;

  localparam int TX_AW = $clog2(TX_DEPTH);
  localparam int RX_AW = $clog2(RX_DEPTH);

  typedef enum logic [1:0] {
    REQ_QUEUE   = 2'd0,
    REQ_SERVICE = 2'd1,
    REQ_CAPTURE = 2'd2,
    REQ_POP     = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    KIND_DONE  = 3'd0,
    KIND_LOAD  = 3'd1,
    KIND_RX    = 3'd2,
    KIND_OVF   = 3'd3,
    KIND_EMPTY = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SVC_CHK,
    ST_SVC_RD,
    ST_POP,
    ST_END
  } state_t;

  typedef struct packed {
    logic [15:0] sid;
    logic [63:0] data;
  } entry_t;

  typedef struct packed {
    logic push;
    logic rd;
    logic pop;
  } tx_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } tx_stat_t;

  typedef struct packed {
    logic wr;
    logic rd;
    logic clr;
  } rx_cmd_t;

  typedef struct packed {
    logic wr_full;
    logic rd_valid;
  } rx_stat_t;

  function automatic logic [15:0] pack_tx_ident(input logic [10:0] id);
    return {id[10:6], 3'b000, id[5:0], 2'b00};
  endfunction

  function automatic logic [15:0] tx_to_rx_ident(input logic [15:0] t);
    return {3'b000, t[15:11], t[7:0]};
  endfunction

endpackage
`default_nettype wire

>>> sv/cmqe_tx_ring.sv
// Transmit ring: entry memory with registered read port, head and tail pointers.
// Depends on cmqe_pkg.
`default_nettype none
module cmqe_tx_ring (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cmqe_pkg::tx_cmd_t cmd,
  input  wire cmqe_pkg::entry_t  wdat,
  output cmqe_pkg::entry_t       rdat,
  output cmqe_pkg::tx_stat_t     stat
);
  import cmqe_pkg::*;

  entry_t           mem [TX_DEPTH];
  entry_t           rdat_r;
  logic [TX_AW-1:0] head_r, head_nxt;
  logic [TX_AW-1:0] tail_r, tail_nxt;
  logic [TX_AW-1:0] tail_inc;

  always_comb begin
    tail_inc = (tail_r == TX_AW'(TX_DEPTH - 1)) ? '0 : tail_r + 1'b1;
    head_nxt = head_r;
    tail_nxt = tail_r;
    if (cmd.push) begin
      tail_nxt = tail_inc;
    end
    if (cmd.pop) begin
      head_nxt = (head_r == TX_AW'(TX_DEPTH - 1)) ? '0 : head_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[tail_r] <= wdat;
    end
    if (cmd.rd) begin
      rdat_r <= mem[head_r];
    end
  end

  assign rdat       = rdat_r;
  assign stat.empty = (head_r == tail_r);
  assign stat.full  = (tail_inc == head_r);

endmodule
`default_nettype wire

>>> sv/cmqe_rx_ring.sv
// Receive ring: entry memory with per-entry valid bits, write and read pointers.
// Depends on cmqe_pkg.
`default_nettype none
module cmqe_rx_ring (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cmqe_pkg::rx_cmd_t cmd,
  input  wire cmqe_pkg::entry_t  wdat,
  output cmqe_pkg::entry_t       rdat,
  output cmqe_pkg::rx_stat_t     stat
);
  import cmqe_pkg::*;

  entry_t           mem [RX_DEPTH];
  entry_t           rdat_r;
  logic [RX_DEPTH-1:0] vld_r, vld_nxt;
  logic [RX_AW-1:0] wptr_r, wptr_nxt;
  logic [RX_AW-1:0] rptr_r, rptr_nxt;

  always_comb begin
    vld_nxt  = vld_r;
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    if (cmd.wr) begin
      vld_nxt[wptr_r] = 1'b1;
      wptr_nxt = (wptr_r == RX_AW'(RX_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (cmd.clr) begin
      vld_nxt[rptr_r] = 1'b0;
      rptr_nxt = (rptr_r == RX_AW'(RX_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      wptr_r <= '0;
      rptr_r <= '0;
    end else begin
      vld_r  <= vld_nxt;
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[wptr_r] <= wdat;
    end
    if (cmd.rd) begin
      rdat_r <= mem[rptr_r];
    end
  end

  assign rdat          = rdat_r;
  assign stat.wr_full  = vld_r[wptr_r];
  assign stat.rd_valid = vld_r[rptr_r];

endmodule
`default_nettype wire

>>> sv/can_message_queue_engine_core.sv
// CAN message queue engine: request sequencer, result staging and output register.
// Depends on cmqe_pkg, cmqe_tx_ring and cmqe_rx_ring.
//
// Input beats carry one request each: in_tuser selects queue, service, capture or pop,
// in_tdata carries identifier, received identifier word, four data words and the
// mailbox busy mask. Output beats carry one result each; out_tuser is the result kind
// and out_tlast marks the final result of a request.
// One request is in work at a time; in_tready is high only while the sequencer idles.
// Queue and capture pass through ST_EXEC and ST_END, pop also through ST_POP when an
// entry is valid, before the result beat enters the output register. A service
// request visits ST_SVC_CHK for each mailbox checked and ST_SVC_RD for each mailbox
// read from the transmit ring, then ST_END; one request may return up to three beats.
// The output register lets the next request be accepted while the last result
// still waits; when the receiver stalls, the sequencer holds on its next result.
// Reset empties both rings at once (receive valid bits are flip-flops) and drops
// any beat in the output register.
`default_nettype none
module can_message_queue_engine_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // tx_ident, rx_sid_word, data_w0, data_w1, data_w2, data_w3, mailbox_busy, pad
  input  wire logic [95:0] in_tdata,
  // req_type
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // mailbox_no, frame_sid, frame_w0, frame_w1, frame_w2, frame_w3, pad
  output logic [87:0]      out_tdata,
  // res_kind
  output logic [2:0]       out_tuser,
  output logic             out_tlast
);
  import cmqe_pkg::*;

  state_t      state_r, state_nxt;
  req_t        req_r, req_nxt;
  logic [10:0] ident_r, ident_nxt;
  logic [15:0] sid_r, sid_nxt;
  logic [63:0] data_r, data_nxt;
  logic [2:0]  busy_r, busy_nxt;
  logic [1:0]  mb_r, mb_nxt;

  logic        hold_vld_r, hold_vld_nxt;
  kind_t       hold_kind_r, hold_kind_nxt;
  logic [1:0]  hold_mb_r, hold_mb_nxt;
  entry_t      hold_ent_r, hold_ent_nxt;

  logic        out_vld_r, out_vld_nxt;
  kind_t       out_kind_r, out_kind_nxt;
  logic [1:0]  out_mb_r, out_mb_nxt;
  entry_t      out_ent_r, out_ent_nxt;
  logic        out_last_r, out_last_nxt;

  logic        out_free;
  tx_cmd_t     tx_cmd;
  tx_stat_t    tx_stat;
  entry_t      tx_wdat, tx_rdat;
  rx_cmd_t     rx_cmd;
  rx_stat_t    rx_stat;
  entry_t      rx_wdat, rx_rdat;

  cmqe_tx_ring u_tx (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (tx_cmd),
    .wdat (tx_wdat),
    .rdat (tx_rdat),
    .stat (tx_stat)
  );

  cmqe_rx_ring u_rx (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (rx_cmd),
    .wdat (rx_wdat),
    .rdat (rx_rdat),
    .stat (rx_stat)
  );

  assign out_free  = !out_vld_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    ident_nxt     = ident_r;
    sid_nxt       = sid_r;
    data_nxt      = data_r;
    busy_nxt      = busy_r;
    mb_nxt        = mb_r;
    hold_vld_nxt  = hold_vld_r;
    hold_kind_nxt = hold_kind_r;
    hold_mb_nxt   = hold_mb_r;
    hold_ent_nxt  = hold_ent_r;
    out_vld_nxt   = out_vld_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_mb_nxt    = out_mb_r;
    out_ent_nxt   = out_ent_r;
    out_last_nxt  = out_last_r;
    tx_cmd        = '0;
    rx_cmd        = '0;
    tx_wdat.sid   = pack_tx_ident(ident_r);
    tx_wdat.data  = data_r;
    rx_wdat.sid   = sid_r;
    rx_wdat.data  = data_r;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          req_nxt      = req_t'(in_tuser);
          ident_nxt    = in_tdata[10:0];
          sid_nxt      = in_tdata[26:11];
          data_nxt     = in_tdata[90:27];
          busy_nxt     = in_tdata[93:91];
          mb_nxt       = 2'(MAILBOXES - 1);
          hold_vld_nxt = 1'b0;
          state_nxt    = (req_t'(in_tuser) == REQ_SERVICE) ? ST_SVC_CHK : ST_EXEC;
        end
      end
      ST_EXEC: begin
        hold_vld_nxt  = 1'b1;
        hold_mb_nxt   = '0;
        hold_ent_nxt  = '0;
        hold_kind_nxt = KIND_DONE;
        state_nxt     = ST_END;
        case (req_r)
          REQ_QUEUE: begin
            if (tx_stat.full) begin
              hold_kind_nxt = KIND_OVF;
            end else begin
              tx_cmd.push = 1'b1;
            end
          end
          REQ_CAPTURE: begin
            if (sid_r != '0) begin
              if (rx_stat.wr_full) begin
                hold_kind_nxt = KIND_OVF;
              end else begin
                rx_cmd.wr = 1'b1;
              end
            end
          end
          REQ_POP: begin
            if (!rx_stat.rd_valid) begin
              hold_kind_nxt = KIND_EMPTY;
            end else begin
              rx_cmd.rd    = 1'b1;
              hold_vld_nxt = 1'b0;
              state_nxt    = ST_POP;
            end
          end
          default: begin
            hold_vld_nxt = 1'b0;
          end
        endcase
      end
      ST_POP: begin
        rx_cmd.clr    = 1'b1;
        hold_vld_nxt  = 1'b1;
        hold_kind_nxt = KIND_RX;
        hold_mb_nxt   = '0;
        hold_ent_nxt  = rx_rdat;
        state_nxt     = ST_END;
      end
      ST_SVC_CHK: begin
        if (tx_stat.empty) begin
          state_nxt = ST_END;
        end else if (busy_r[mb_r]) begin
          if (mb_r == '0) begin
            state_nxt = ST_END;
          end else begin
            mb_nxt = mb_r - 1'b1;
          end
        end else begin
          tx_cmd.rd = 1'b1;
          state_nxt = ST_SVC_RD;
        end
      end
      ST_SVC_RD: begin
        rx_wdat.sid  = tx_to_rx_ident(tx_rdat.sid);
        rx_wdat.data = tx_rdat.data;
        if (tx_rdat.sid == '0) begin
          tx_cmd.pop = 1'b1;
          if (mb_r == '0) begin
            state_nxt = ST_END;
          end else begin
            mb_nxt    = mb_r - 1'b1;
            state_nxt = ST_SVC_CHK;
          end
        end else if (!hold_vld_r || out_free) begin
          if (hold_vld_r) begin
            out_vld_nxt  = 1'b1;
            out_kind_nxt = hold_kind_r;
            out_mb_nxt   = hold_mb_r;
            out_ent_nxt  = hold_ent_r;
            out_last_nxt = 1'b0;
          end
          hold_vld_nxt = 1'b1;
          hold_mb_nxt  = mb_r;
          if (rx_stat.wr_full) begin
            hold_kind_nxt = KIND_OVF;
            hold_ent_nxt  = '0;
            state_nxt     = ST_END;
          end else begin
            rx_cmd.wr     = 1'b1;
            tx_cmd.pop    = 1'b1;
            hold_kind_nxt = KIND_LOAD;
            hold_ent_nxt  = tx_rdat;
            if (mb_r == '0) begin
              state_nxt = ST_END;
            end else begin
              mb_nxt    = mb_r - 1'b1;
              state_nxt = ST_SVC_CHK;
            end
          end
        end
      end
      ST_END: begin
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_last_nxt = 1'b1;
          if (hold_vld_r) begin
            out_kind_nxt = hold_kind_r;
            out_mb_nxt   = hold_mb_r;
            out_ent_nxt  = hold_ent_r;
          end else begin
            out_kind_nxt = KIND_DONE;
            out_mb_nxt   = '0;
            out_ent_nxt  = '0;
          end
          hold_vld_nxt = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      hold_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      hold_vld_r <= hold_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    ident_r     <= ident_nxt;
    sid_r       <= sid_nxt;
    data_r      <= data_nxt;
    busy_r      <= busy_nxt;
    mb_r        <= mb_nxt;
    hold_kind_r <= hold_kind_nxt;
    hold_mb_r   <= hold_mb_nxt;
    hold_ent_r  <= hold_ent_nxt;
    out_kind_r  <= out_kind_nxt;
    out_mb_r    <= out_mb_nxt;
    out_ent_r   <= out_ent_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {6'b0, out_ent_r.data, out_ent_r.sid, out_mb_r};

endmodule
`default_nettype wire

>>> tb/tb_can_message_queue_engine_core.sv
// Self-checking testbench for can_message_queue_engine_core: queue, service, capture and
// pop requests, with ring-full and ring-empty handling, checked beat by beat.
// Depends on cmqe_pkg and the engine RTL; predicts results from its own copy of both rings.
module tb_can_message_queue_engine_core;
  timeunit 1ns;
  timeprecision 1ps;
  import cmqe_pkg::*;

  typedef struct packed {
    req_t        req;
    logic [10:0] ident;
    logic [15:0] sid_word;
    logic [63:0] data;
    logic [2:0]  busy;
  } can_req_t;

  typedef struct packed {
    kind_t       kind;
    logic [1:0]  mbox;
    logic [15:0] sid;
    logic [63:0] data;
    logic        last;
  } can_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [87:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  can_message_queue_engine_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  can_req_t pending_reqs[$];
  can_res_t expected_results[$];
  int       error_count = 0;

  logic [15:0]      txq_ident[TX_DEPTH];
  logic [63:0]      txq_data[TX_DEPTH];
  logic [TX_AW-1:0] txq_head = '0;
  logic [TX_AW-1:0] txq_tail = '0;
  logic [15:0]      rxq_ident[RX_DEPTH];
  logic [63:0]      rxq_data[RX_DEPTH];
  logic [RX_AW-1:0] rxq_wr = '0;
  logic [RX_AW-1:0] rxq_rd = '0;

  function automatic logic [15:0] to_tx_layout(logic [10:0] id);
    logic [15:0] w;
    w = {5'b0, id};
    return ((w & 16'h003F) << 2) | ((w & 16'h07C0) << 5);
  endfunction

  function automatic logic [15:0] to_rx_layout(logic [15:0] t);
    return (t & 16'h00FF) + ((t & 16'hF800) >> 3);
  endfunction

  function automatic can_res_t mk_res(kind_t k, logic [1:0] mb, logic [15:0] sid,
                                      logic [63:0] data);
    can_res_t r;
    r.kind = k;
    r.mbox = mb;
    r.sid  = sid;
    r.data = data;
    r.last = 1'b0;
    return r;
  endfunction

  task automatic predict_request(input can_req_t r);
    can_res_t         batch[$];
    logic [15:0]      sid;
    logic [TX_AW-1:0] next_tail;
    logic             stop;
    int               mb;
    case (r.req)
      REQ_QUEUE: begin
        next_tail = txq_tail + 1'b1;
        if (next_tail == txq_head) begin
          batch.push_back(mk_res(KIND_OVF, 2'd0, 16'd0, 64'd0));
        end else begin
          txq_ident[txq_tail] = to_tx_layout(r.ident);
          txq_data[txq_tail]  = r.data;
          txq_tail = next_tail;
          batch.push_back(mk_res(KIND_DONE, 2'd0, 16'd0, 64'd0));
        end
      end
      REQ_SERVICE: begin
        stop = 1'b0;
        for (mb = MAILBOXES - 1; mb >= 0 && !stop; mb--) begin
          if (txq_head == txq_tail) begin
            stop = 1'b1;
          end else if (!r.busy[mb]) begin
            sid = txq_ident[txq_head];
            if (sid == 16'd0) begin
              txq_head = txq_head + 1'b1;
            end else if (rxq_ident[rxq_wr] != 16'd0) begin
              batch.push_back(mk_res(KIND_OVF, mb[1:0], 16'd0, 64'd0));
              stop = 1'b1;
            end else begin
              rxq_ident[rxq_wr] = to_rx_layout(sid);
              rxq_data[rxq_wr]  = txq_data[txq_head];
              rxq_wr = rxq_wr + 1'b1;
              batch.push_back(mk_res(KIND_LOAD, mb[1:0], sid, txq_data[txq_head]));
              txq_head = txq_head + 1'b1;
            end
          end
        end
        if (batch.size() == 0) batch.push_back(mk_res(KIND_DONE, 2'd0, 16'd0, 64'd0));
      end
      REQ_CAPTURE: begin
        if (r.sid_word != 16'd0 && rxq_ident[rxq_wr] != 16'd0) begin
          batch.push_back(mk_res(KIND_OVF, 2'd0, 16'd0, 64'd0));
        end else begin
          if (r.sid_word != 16'd0) begin
            rxq_ident[rxq_wr] = r.sid_word;
            rxq_data[rxq_wr]  = r.data;
            rxq_wr = rxq_wr + 1'b1;
          end
          batch.push_back(mk_res(KIND_DONE, 2'd0, 16'd0, 64'd0));
        end
      end
      default: begin
        if (rxq_ident[rxq_rd] == 16'd0) begin
          batch.push_back(mk_res(KIND_EMPTY, 2'd0, 16'd0, 64'd0));
        end else begin
          batch.push_back(mk_res(KIND_RX, 2'd0, rxq_ident[rxq_rd], rxq_data[rxq_rd]));
          rxq_ident[rxq_rd] = 16'd0;
          rxq_rd = rxq_rd + 1'b1;
        end
      end
    endcase
    batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) expected_results.push_back(batch[i]);
  endtask

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    error_count++;
    $display("%0t ERROR %s: got %h, expected %h", $realtime, what, got, want);
  endtask

  task automatic check_field(string what, logic [15:0] got, logic [15:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // driver
  can_req_t cur_req;
  int       burst_left = 1;
  int       gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        predict_request(cur_req);
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      if (gap_left > 0 || pending_reqs.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_tvalid <= 1'b0;
      end else begin
        cur_req = pending_reqs.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {2'b00, cur_req.busy, cur_req.data, cur_req.sid_word, cur_req.ident};
        in_tuser  <= cur_req.req;
      end
    end
  end

  // receiver stall pattern
  logic [15:0] stall_bits = 16'hFFFF;
  int          stall_age = 0;

  always @(posedge clk) begin
    out_tready <= stall_bits[0];
    stall_bits = {stall_bits[0], stall_bits[15:1]};
    stall_age++;
    if (stall_age == 64) begin
      stall_age = 0;
      stall_bits = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom()) | 16'h0001);
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    can_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("beat with nothing expected", {13'd0, out_tuser}, 16'd0);
      end else begin
        want = expected_results.pop_front();
        check_field("res_kind", {13'd0, out_tuser}, {13'd0, want.kind});
        check_field("mailbox_no", {14'd0, out_tdata[1:0]}, {14'd0, want.mbox});
        check_field("frame_sid", out_tdata[17:2], want.sid);
        check_field("frame_w0", out_tdata[33:18], want.data[15:0]);
        check_field("frame_w1", out_tdata[49:34], want.data[31:16]);
        check_field("frame_w2", out_tdata[65:50], want.data[47:32]);
        check_field("frame_w3", out_tdata[81:66], want.data[63:48]);
        check_field("last_result", {15'd0, out_tlast}, {15'd0, want.last});
      end
    end
  end

  function automatic can_req_t mk_req(req_t req, logic [10:0] ident, logic [15:0] sid,
                                      logic [63:0] data, logic [2:0] busy);
    can_req_t r;
    r.req      = req;
    r.ident    = ident;
    r.sid_word = sid;
    r.data     = data;
    r.busy     = busy;
    return r;
  endfunction

  function automatic logic [63:0] rand_words();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [10:0] rand_ident();
    return ($urandom_range(0, 7) == 0) ? 11'd0 : 11'($urandom_range(1, 2047));
  endfunction

  function automatic logic [15:0] rand_sid();
    return ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
  endfunction

  function automatic can_req_t rand_req(req_t req);
    logic [2:0] busy;
    busy = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(1, 7)) : 3'd0;
    return mk_req(req, rand_ident(), rand_sid(), rand_words(), busy);
  endfunction

  initial begin
    int i;
    foreach (rxq_ident[k]) rxq_ident[k] = 16'd0;

    pending_reqs.push_back(mk_req(REQ_POP, 11'd0, 16'd0, 64'd0, 3'd0));
    pending_reqs.push_back(mk_req(REQ_SERVICE, 11'd0, 16'd0, 64'd0, 3'd0));
    pending_reqs.push_back(mk_req(REQ_CAPTURE, 11'h7FF, 16'd0, '1, 3'd7));
    pending_reqs.push_back(mk_req(REQ_CAPTURE, 11'd0, 16'hFFFF, '1, 3'd0));
    pending_reqs.push_back(mk_req(REQ_CAPTURE, 11'd0, 16'h0001, 64'd0, 3'd0));
    pending_reqs.push_back(mk_req(REQ_POP, 11'd0, 16'd0, 64'd0, 3'd0));
    pending_reqs.push_back(mk_req(REQ_POP, 11'd0, 16'd0, 64'd0, 3'd0));
    pending_reqs.push_back(mk_req(REQ_POP, 11'd0, 16'd0, 64'd0, 3'd0));
    pending_reqs.push_back(mk_req(REQ_QUEUE, 11'h7FF, 16'hFFFF, '1, 3'd0));
    pending_reqs.push_back(mk_req(REQ_QUEUE, 11'd0, 16'd0, 64'h0123_4567_89AB_CDEF, 3'd0));
    pending_reqs.push_back(mk_req(REQ_QUEUE, 11'h001, 16'd0, 64'd0, 3'd0));
    pending_reqs.push_back(mk_req(REQ_QUEUE, 11'h040, 16'd0, 64'hA5A5_5A5A_F00F_0FF0, 3'd0));
    pending_reqs.push_back(mk_req(REQ_SERVICE, 11'd0, 16'd0, 64'd0, 3'b111));
    pending_reqs.push_back(mk_req(REQ_SERVICE, 11'd0, 16'd0, 64'd0, 3'b010));
    pending_reqs.push_back(mk_req(REQ_SERVICE, 11'd0, 16'd0, 64'd0, 3'b000));
    pending_reqs.push_back(mk_req(REQ_POP, 11'd0, 16'd0, 64'd0, 3'd0));
    pending_reqs.push_back(mk_req(REQ_POP, 11'd0, 16'd0, 64'd0, 3'd0));
    pending_reqs.push_back(mk_req(REQ_POP, 11'd0, 16'd0, 64'd0, 3'd0));
    pending_reqs.push_back(mk_req(REQ_POP, 11'd0, 16'd0, 64'd0, 3'd0));
    pending_reqs.push_back(mk_req(REQ_QUEUE, 11'h555, 16'd0, rand_words(), 3'd0));
    pending_reqs.push_back(mk_req(REQ_SERVICE, 11'd0, 16'd0, 64'd0, 3'b100));
    pending_reqs.push_back(mk_req(REQ_POP, 11'd0, 16'd0, 64'd0, 3'd0));

    // overfill the transmit ring, then drain it into a partly filled receive ring
    for (i = 0; i < 66; i++) pending_reqs.push_back(rand_req(REQ_QUEUE));
    for (i = 0; i < 16; i++) pending_reqs.push_back(rand_req(REQ_CAPTURE));
    for (i = 0; i < 26; i++) pending_reqs.push_back(rand_req(REQ_SERVICE));
    for (i = 0; i < 3; i++) pending_reqs.push_back(rand_req(REQ_CAPTURE));
    for (i = 0; i < 68; i++) pending_reqs.push_back(rand_req(REQ_POP));
    for (i = 0; i < 45; i++) pending_reqs.push_back(rand_req(req_t'($urandom_range(0, 3))));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (pending_reqs.size() != 0 || in_tvalid || expected_results.size() != 0);
    repeat (40) @(posedge clk);

    if (error_count == 0) begin
      $display("can_message_queue_engine_core: match");
    end else begin
      $display("can_message_queue_engine_core: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("can_message_queue_engine_core: mismatch");
    $finish;
  end

endmodule
